### hdl/aees_pkg.sv
`default_nettype none

package aees_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MVOL_W      = 4;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned IN_DATA_W   = 80;
    localparam int unsigned OUT_DATA_W  = 48;

    localparam int unsigned ST_START_BIT = 7;
    localparam int unsigned ST_STOP_BIT  = 6;
    localparam int unsigned ST_ECHO_BIT  = 2;

    localparam logic [7:0] ST_ACTIVE_MASK = 8'hC7;
    localparam logic [7:0] ST_PHASE_MASK  = 8'h03;
    localparam logic [7:0] ST_ECHO_MASK   = 8'h04;
    localparam logic [7:0] ST_KILLED      = 8'h00;
    localparam logic [7:0] ATTACK_LIMIT   = 8'hFE;
    localparam logic [7:0] ENV_FULL       = 8'hFF;

    localparam logic [1:0] PH_ATTACK  = 2'd3;
    localparam logic [1:0] PH_DECAY   = 2'd2;
    localparam logic [1:0] PH_SUSTAIN = 2'd1;

    typedef enum logic [2:0] {
        OP_PASS,
        OP_KILL,
        OP_HOLD,
        OP_ATTACK,
        OP_DECAY,
        OP_RELEASE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       started;
        logic [7:0] status;
        logic [7:0] envelope;
        logic [7:0] attack_rate;
        logic [7:0] decay_rate;
        logic [7:0] sustain_level;
        logic [7:0] release_rate;
        logic [7:0] echo_level;
        logic [7:0] echo_count;
        logic [7:0] right_pan;
        logic [7:0] left_pan;
    } t_item;

endpackage

`default_nettype wire

### hdl/aees_front.sv
`default_nettype none

module aees_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [aees_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               o_push,
    output aees_pkg::t_item                    o_item,
    input  wire                                i_full
);
    import aees_pkg::*;

    logic       r_valid;
    t_item      r_item;
    t_item      n_item;
    logic [7:0] st;
    logic [7:0] cnt_dec;

    always_comb begin
        st      = s_axis_tdata[7:0];
        cnt_dec = s_axis_tdata[63:56] - 8'd1;

        n_item               = '0;
        n_item.op            = OP_PASS;
        n_item.started       = 1'b0;
        n_item.status        = st;
        n_item.envelope      = s_axis_tdata[15:8];
        n_item.attack_rate   = s_axis_tdata[23:16];
        n_item.decay_rate    = s_axis_tdata[31:24];
        n_item.sustain_level = s_axis_tdata[39:32];
        n_item.release_rate  = s_axis_tdata[47:40];
        n_item.echo_level    = s_axis_tdata[55:48];
        n_item.echo_count    = s_axis_tdata[63:56];
        n_item.right_pan     = s_axis_tdata[71:64];
        n_item.left_pan      = s_axis_tdata[79:72];

        if ((st & ST_ACTIVE_MASK) != 8'd0) begin
            if (st[ST_START_BIT]) begin
                if (st[ST_STOP_BIT]) begin
                    n_item.op = OP_KILL;
                end else begin
                    n_item.op       = OP_ATTACK;
                    n_item.started  = 1'b1;
                    n_item.status   = {6'd0, PH_ATTACK};
                    n_item.envelope = 8'd0;
                end
            end else if (st[ST_ECHO_BIT]) begin
                n_item.echo_count = cnt_dec;
                if (s_axis_tdata[63:56] == 8'd0 || cnt_dec == 8'd0) begin
                    n_item.op = OP_KILL;
                end else begin
                    n_item.op = OP_HOLD;
                end
            end else if (st[ST_STOP_BIT]) begin
                n_item.op = OP_RELEASE;
            end else if (st[1:0] == PH_DECAY) begin
                n_item.op = OP_DECAY;
            end else if (st[1:0] == PH_ATTACK) begin
                n_item.op = OP_ATTACK;
            end else begin
                n_item.op = OP_HOLD;
            end
        end
    end

    assign s_axis_tready = !r_valid || !i_full;
    assign o_push        = r_valid && !i_full;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

### hdl/aees_queue.sv
`default_nettype none

module aees_queue #(
    parameter int unsigned DEPTH = aees_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  aees_pkg::t_item  i_item,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output aees_pkg::t_item  o_item
);
    import aees_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count above depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("beat pushed into a full queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue fill count lost a beat");
`endif

endmodule

`default_nettype wire

### hdl/aees_back.sv
`default_nettype none

module aees_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [aees_pkg::MVOL_W-1:0]        i_master_volume,
    input  wire                                i_valid,
    input  aees_pkg::t_item                    i_item,
    output logic                               o_pop,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [aees_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import aees_pkg::*;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] envelope;
        logic [7:0] echo_count;
        logic [7:0] right_pan;
        logic [7:0] left_pan;
        logic       mute;
        logic       started;
    } t_stage;

    logic       r_v1, r_v2, r_v3;
    t_stage     r_s1, r_s2, n_s1;
    logic [7:0] r_scaled2;
    logic [7:0] r_right3, r_left3;
    logic [7:0] r_status3, r_env3, r_cnt3;
    logic       r_started3, r_mute3;
    logic       en1, en2, en3;

    logic [7:0]  rate;
    logic [15:0] prod;
    logic [7:0]  scaled_env;
    logic [8:0]  att_sum;
    logic        to_echo;
    logic [12:0] vol_prod;
    logic [15:0] right_prod, left_prod;

    assign en3   = !r_v3 || m_axis_tready;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = en1 && i_valid;

    always_comb begin
        rate       = (i_item.op == OP_RELEASE) ? i_item.release_rate : i_item.decay_rate;
        prod       = i_item.envelope * rate;
        scaled_env = prod[15:8];
        att_sum    = {1'b0, i_item.envelope} + {1'b0, i_item.attack_rate};
        to_echo    = 1'b0;

        n_s1.status     = i_item.status;
        n_s1.envelope   = i_item.envelope;
        n_s1.echo_count = i_item.echo_count;
        n_s1.right_pan  = i_item.right_pan;
        n_s1.left_pan   = i_item.left_pan;
        n_s1.mute       = 1'b0;
        n_s1.started    = i_item.started;

        unique case (i_item.op)
            OP_PASS: begin
                n_s1.mute = 1'b1;
            end
            OP_KILL: begin
                n_s1.mute   = 1'b1;
                n_s1.status = ST_KILLED;
            end
            OP_HOLD: begin
            end
            OP_ATTACK: begin
                if (att_sum > {1'b0, ATTACK_LIMIT}) begin
                    n_s1.status   = (i_item.status & ~ST_PHASE_MASK) | {6'd0, PH_DECAY};
                    n_s1.envelope = ENV_FULL;
                end else begin
                    n_s1.envelope = att_sum[7:0];
                end
            end
            OP_DECAY: begin
                n_s1.envelope = scaled_env;
                if (scaled_env <= i_item.sustain_level) begin
                    if (i_item.sustain_level == 8'd0) begin
                        to_echo = 1'b1;
                    end else begin
                        n_s1.status = (i_item.status & ~ST_PHASE_MASK)
                                    | {6'd0, PH_SUSTAIN};
                        n_s1.envelope = i_item.sustain_level;
                    end
                end
            end
            OP_RELEASE: begin
                n_s1.envelope = scaled_env;
                to_echo       = (scaled_env <= i_item.echo_level);
            end
            default: begin
                n_s1.mute = 1'b1;
            end
        endcase

        if (to_echo) begin
            if (i_item.echo_level == 8'd0) begin
                n_s1.mute     = 1'b1;
                n_s1.status   = ST_KILLED;
                n_s1.envelope = i_item.envelope;
            end else begin
                n_s1.status   = i_item.status | ST_ECHO_MASK;
                n_s1.envelope = i_item.echo_level;
            end
        end
    end

    assign vol_prod   = r_s1.envelope * ({1'b0, i_master_volume} + 5'd1);
    assign right_prod = r_scaled2 * r_s2.right_pan;
    assign left_prod  = r_scaled2 * r_s2.left_pan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_s1 <= n_s1;
        end
        if (en2 && r_v1) begin
            r_s2      <= r_s1;
            r_scaled2 <= vol_prod[11:4];
        end
        if (en3 && r_v2) begin
            r_status3  <= r_s2.status;
            r_env3     <= r_s2.envelope;
            r_cnt3     <= r_s2.echo_count;
            r_started3 <= r_s2.started;
            r_mute3    <= r_s2.mute;
            r_right3   <= r_s2.mute ? 8'd0 : right_prod[15:8];
            r_left3    <= r_s2.mute ? 8'd0 : left_prod[15:8];
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {7'd0, r_started3, r_left3, r_right3, r_cnt3, r_env3, r_status3};

`ifndef SYNTH
    a_mute_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_mute3) |-> (r_right3 == 8'd0 && r_left3 == 8'd0))
        else $error("silenced voice gave a non-zero level");
    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_started3) |->
            (r_status3 == {6'd0, PH_ATTACK} || r_status3 == {6'd0, PH_DECAY}))
        else $error("note start left a stray status");
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en3) |=> r_v2)
        else $error("stalled beat dropped from stage two");
`endif

endmodule

`default_nettype wire

### hdl/adsr_echo_envelope_step_core.sv
`default_nettype none

// Envelope step for one sound voice: each input beat is one voice record for
// one frame, and each output beat is the updated record with its two stereo
// levels. The core takes one beat per clock cycle when the output side keeps
// up; a beat passes through an input register, a small queue and a three
// stage back end (rate multiply, master volume scaling, pan scaling) before it
// appears at the output.
// The master volume register is written from the configuration port and must
// only change while no beat is in flight.
module adsr_echo_envelope_step_core #(
    parameter int unsigned QUEUE_DEPTH = aees_pkg::QUEUE_DEPTH
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire  [aees_pkg::MVOL_W-1:0]        i_cfg_wr_data,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // voice_status, envelope_level, attack_rate, decay_rate, sustain_level,
    // release_rate, echo_level, echo_count, right_pan, left_pan
    input  wire  [aees_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // new_status, new_envelope, new_echo_count, right_level, left_level,
    // note_started, zero padding
    output logic [aees_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import aees_pkg::*;

    logic [MVOL_W-1:0] r_master_volume;
    logic              push, full, pop, q_valid;
    t_item             front_item, queue_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_volume <= {MVOL_W{1'b1}};
        end else if (i_cfg_wr_en) begin
            r_master_volume <= i_cfg_wr_data;
        end
    end

    aees_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_push        (push),
        .o_item        (front_item),
        .i_full        (full)
    );

    aees_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (queue_item)
    );

    aees_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_master_volume (r_master_volume),
        .i_valid         (q_valid),
        .i_item          (queue_item),
        .o_pop           (pop),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata)
    );

endmodule

`default_nettype wire
